/* rtl/tfel_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfel_pkg
// Shared types, codes and sizes of the timestamped fault event log.
// ----------------------------------------------------------------------------
package tfel_pkg;

  // Sizes
  localparam int NUM_EVENTS  = 32;
  localparam int EV_IW       = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int LOG_SLOTS   = 60;
  localparam int SLOT_W      = 6;
  localparam int STORE_DEPTH = 64;

  typedef logic [SLOT_W-1:0] slot_t;

  // Request codes
  typedef enum logic [1:0] {
    REQ_REPORT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  // Result actions
  typedef enum logic [2:0] {
    ACT_BAD_CODE   = 3'd0,
    ACT_UNCHANGED  = 3'd1,
    ACT_ALREADY_OP = 3'd2,
    ACT_OPENED     = 3'd3,
    ACT_CLEARED    = 3'd4,
    ACT_UNMATCHED  = 3'd5,
    ACT_READ       = 3'd6,
    ACT_LOG_CLEAR  = 3'd7
  } action_t;

  // Slot states
  typedef enum logic [1:0] {
    ENT_EMPTY   = 2'd0,
    ENT_OPEN    = 2'd1,
    ENT_CLEARED = 2'd2,
    ENT_UNUSED  = 2'd3
  } entry_state_t;

  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
  } stamp_t;

  typedef struct packed {
    logic [4:0]   code;
    entry_state_t state;
    stamp_t       start;
    stamp_t       stop;
  } log_entry_t;

  typedef struct packed {
    action_t    action;
    slot_t      slot;
    log_entry_t entry;
  } result_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

/* rtl/tfel_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfel_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface tfel_in_if import tfel_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [4:0] event_num;
  logic       event_active;
  logic [5:0] now_minute;
  logic [4:0] now_hour;
  logic [4:0] now_day;
  logic [3:0] now_month;
  logic [5:0] read_slot;

  modport source (
    output valid, req_type, event_num, event_active,
           now_minute, now_hour, now_day, now_month, read_slot,
    input  ready
  );
  modport sink (
    input  valid, req_type, event_num, event_active,
           now_minute, now_hour, now_day, now_month, read_slot,
    output ready
  );
endinterface

interface tfel_out_if import tfel_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [5:0] slot;
  logic [4:0] entry_code;
  logic [1:0] entry_state;
  logic [5:0] start_minute;
  logic [4:0] start_hour;
  logic [4:0] start_day;
  logic [3:0] start_month;
  logic [5:0] end_minute;
  logic [4:0] end_hour;
  logic [4:0] end_day;
  logic [3:0] end_month;

  modport source (
    output valid, action, slot, entry_code, entry_state,
           start_minute, start_hour, start_day, start_month,
           end_minute, end_hour, end_day, end_month,
    input  ready
  );
  modport sink (
    input  valid, action, slot, entry_code, entry_state,
           start_minute, start_hour, start_day, start_month,
           end_minute, end_hour, end_day, end_month,
    output ready
  );
endinterface

/* rtl/tfel_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfel_ram
// Generic single-clock RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tfel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/timestamped_fault_event_log.sv */
`timescale 1ns / 1ps
// A result word is loaded in the execute step that follows its accepted request
// word, once the result register is free. Request words are taken only in idle:
// the log store slot is read at accept, then checked, written back, result loaded.
// Reset (rst_n low, synchronous) clears the sequencer, newest slot, event
// status and locations, and the per-slot valid bits, so every slot reads zero
// at once; no clearing sweep runs. A clear request clears all but the sequencer.
// ----------------------------------------------------------------------------
// timestamped_fault_event_log
// Records activation and clearing times of fault events in a cyclic log.
// ----------------------------------------------------------------------------
module timestamped_fault_event_log import tfel_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  tfel_in_if.sink        in_ch,
  tfel_out_if.source     out_ch
);

  localparam slot_t LAST_SLOT = slot_t'(LOG_SLOTS);
  localparam logic [EV_IW:0] EV_LIMIT = (EV_IW + 1)'(NUM_EVENTS);

  state_t state_r, state_nxt;

  // Request captured at accept
  req_type_t        req_r;
  logic [4:0]       code_r;
  logic             active_r;
  stamp_t           now_r;
  slot_t            addr_r;
  logic             code_ok_r;
  logic             rd_valid_r;

  // Control state
  slot_t                   newest_r, newest_nxt;
  logic [NUM_EVENTS-1:0]   status_r;
  slot_t                   loc_r [NUM_EVENTS];
  logic [STORE_DEPTH-1:0]  valid_r;

  // Output register
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, res_nxt;

  // RAM port
  log_entry_t ram_q, ram_wdata;
  log_entry_t rd_entry;
  logic       ram_we, ram_re;
  slot_t      ram_waddr, ram_raddr;

  logic            in_fire, exec_go;
  logic [EV_IW-1:0] in_idx, ev_idx;
  logic            in_code_ok;
  slot_t           base_slot, open_slot;
  logic            set_status, clr_status, do_open, do_clear;

  tfel_ram #(
    .WIDTH ($bits(log_entry_t)),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    exec_go     = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_EXEC: exec_go = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign in_fire = in_ch.valid && in_ch.ready;
  assign ram_re  = in_fire;

  // Select the slot to read for the incoming word
  assign in_idx     = in_ch.event_num[EV_IW-1:0];
  assign in_code_ok = {1'b0, in_ch.event_num[EV_IW-1:0]} < EV_LIMIT
                      && ((EV_IW == 5) || (in_ch.event_num >> EV_IW) == '0);
  always_comb begin
    if (req_type_t'(in_ch.req_type) == REQ_READ) begin
      ram_raddr = in_ch.read_slot;
    end else if (in_code_ok) begin
      ram_raddr = loc_r[in_idx];
    end else begin
      ram_raddr = '0;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r       <= req_type_t'(in_ch.req_type);
      code_r      <= in_ch.event_num;
      active_r    <= in_ch.event_active;
      now_r       <= '{minute: in_ch.now_minute, hour: in_ch.now_hour,
                       day: in_ch.now_day, month: in_ch.now_month};
      addr_r      <= ram_raddr;
      code_ok_r   <= in_code_ok;
      rd_valid_r  <= valid_r[ram_raddr];
    end
  end

  // Slot never written reads as zero
  assign rd_entry = rd_valid_r ? ram_q : '0;
  assign ev_idx   = code_r[EV_IW-1:0];

  // Next slot for an activation
  assign base_slot = (newest_r >= LAST_SLOT) ? '0 : newest_r;
  assign open_slot = base_slot + slot_t'(1);

  // Check, modify and write back
  always_comb begin
    res_nxt    = '{action: ACT_BAD_CODE, slot: '0, entry: '0};
    ram_we     = 1'b0;
    ram_waddr  = addr_r;
    ram_wdata  = rd_entry;
    set_status = 1'b0;
    clr_status = 1'b0;
    do_open    = 1'b0;
    do_clear   = 1'b0;
    case (req_r)
      REQ_READ: begin
        res_nxt = '{action: ACT_READ, slot: newest_r, entry: rd_entry};
      end
      REQ_CLEAR: begin
        res_nxt  = '{action: ACT_LOG_CLEAR, slot: '0, entry: '0};
        do_clear = 1'b1;
      end
      REQ_REPORT: begin
        if (!code_ok_r) begin
          res_nxt = '{action: ACT_BAD_CODE, slot: '0, entry: '0};
        end else if (active_r == status_r[ev_idx]) begin
          res_nxt = '{action: ACT_UNCHANGED, slot: addr_r, entry: rd_entry};
        end else if (active_r) begin
          if (rd_entry.state == ENT_OPEN) begin
            res_nxt = '{action: ACT_ALREADY_OP, slot: addr_r, entry: rd_entry};
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = open_slot;
            ram_wdata  = '{code: code_r, state: ENT_OPEN, start: now_r, stop: '0};
            set_status = 1'b1;
            do_open    = 1'b1;
            res_nxt    = '{action: ACT_OPENED, slot: open_slot, entry: ram_wdata};
          end
        end else begin
          clr_status = 1'b1;
          if (rd_entry.code == code_r) begin
            ram_we          = 1'b1;
            ram_wdata.stop  = now_r;
            ram_wdata.state = ENT_CLEARED;
            res_nxt = '{action: ACT_CLEARED, slot: addr_r, entry: ram_wdata};
          end else begin
            res_nxt = '{action: ACT_UNMATCHED, slot: addr_r, entry: rd_entry};
          end
        end
      end
      default: begin
        res_nxt = '{action: ACT_BAD_CODE, slot: '0, entry: '0};
      end
    endcase
    if (!exec_go) begin
      ram_we = 1'b0;
    end
  end

  assign newest_nxt    = (exec_go && do_open) ? open_slot : newest_r;
  assign out_valid_nxt = exec_go ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n || (exec_go && do_clear)) begin
      newest_r <= '0;
      status_r <= '0;
      valid_r  <= '0;
      for (int i = 0; i < NUM_EVENTS; i++) begin
        loc_r[i] <= '0;
      end
    end else begin
      newest_r <= newest_nxt;
      if (exec_go && set_status) begin
        status_r[ev_idx] <= 1'b1;
        loc_r[ev_idx]    <= open_slot;
      end
      if (exec_go && clr_status) begin
        status_r[ev_idx] <= 1'b0;
      end
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_res_r <= res_nxt;
    end
  end

  // Drive the result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.action       = out_res_r.action;
  assign out_ch.slot         = out_res_r.slot;
  assign out_ch.entry_code   = out_res_r.entry.code;
  assign out_ch.entry_state  = out_res_r.entry.state;
  assign out_ch.start_minute = out_res_r.entry.start.minute;
  assign out_ch.start_hour   = out_res_r.entry.start.hour;
  assign out_ch.start_day    = out_res_r.entry.start.day;
  assign out_ch.start_month  = out_res_r.entry.start.month;
  assign out_ch.end_minute   = out_res_r.entry.stop.minute;
  assign out_ch.end_hour     = out_res_r.entry.stop.hour;
  assign out_ch.end_day      = out_res_r.entry.stop.day;
  assign out_ch.end_month    = out_res_r.entry.stop.month;

  // Write-back only happens in the execute step
  a_we_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_EXEC))
    else $error("log store written outside execute step");

  // An accepted word is executed next
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted word did not reach execute step");

  // A result appears only out of the execute step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(exec_go))
    else $error("result word without execute step");

  // An opened slot stays within 1..LOG_SLOTS
  a_open_range: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && do_open) |=> (newest_r != '0) && (newest_r <= LAST_SLOT))
    else $error("newest slot out of range after activation");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timestamped fault event log. A scoreboard keeps
// its own copy of the event status, slot pointers and log store, works out the
// result word for every accepted request word and compares each returned word
// field by field. A short directed run covers the edge values and six actions.
// A long random run of report sequences, reads and rare log clears follows,
// under several idle and stall patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import tfel_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 4;
  localparam int WORDS_PER_PASS = 120;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 20;
  localparam int MAX_PRINTED    = 50;

  typedef struct packed {
    req_type_t   req;
    logic [4:0]  code;
    logic        active;
    stamp_t      now;
    slot_t       rd_slot;
  } request_t;

  // Predicts the log's answers and holds the words still due from the block
  class fault_log_scoreboard;
    slot_t      newest;
    bit         ev_status [NUM_EVENTS];
    slot_t      ev_loc [NUM_EVENTS];
    log_entry_t store [STORE_DEPTH];
    result_t    due_results [$];
    int         errors;
    int         checked;
    int         act_count [8];

    function new();
      wipe_log();
    endfunction

    function void wipe_log();
      newest = '0;
      foreach (ev_status[i]) ev_status[i] = 1'b0;
      foreach (ev_loc[i]) ev_loc[i] = '0;
      foreach (store[i]) store[i] = '0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Apply one request word to the log copy and return the answer
    function result_t apply_request(request_t w);
      result_t    r;
      slot_t      s;
      log_entry_t e;
      r = '0;
      case (w.req)
        REQ_READ: begin
          r.action = ACT_READ;
          r.slot   = newest;
          r.entry  = store[w.rd_slot];
        end
        REQ_CLEAR: begin
          wipe_log();
          r.action = ACT_LOG_CLEAR;
        end
        REQ_REPORT: begin
          if (int'(w.code) >= NUM_EVENTS) begin
            r.action = ACT_BAD_CODE;
          end else if (w.active == ev_status[w.code]) begin
            s        = ev_loc[w.code];
            r.action = ACT_UNCHANGED;
            r.slot   = s;
            r.entry  = store[s];
          end else if (w.active) begin
            s = ev_loc[w.code];
            if (store[s].state == ENT_OPEN) begin
              r.action = ACT_ALREADY_OP;
              r.slot   = s;
              r.entry  = store[s];
            end else begin
              // advance the newest slot, wrapping back to 1 past the end
              s = (int'(newest) >= LOG_SLOTS) ? slot_t'(1) : slot_t'(newest + 1'b1);
              newest            = s;
              ev_loc[w.code]    = s;
              e                 = '0;
              e.code            = w.code;
              e.state           = ENT_OPEN;
              e.start           = w.now;
              store[s]          = e;
              ev_status[w.code] = 1'b1;
              r.action          = ACT_OPENED;
              r.slot            = s;
              r.entry           = e;
            end
          end else begin
            // close the slot only if it still holds this event
            s        = ev_loc[w.code];
            e        = store[s];
            r.action = ACT_UNMATCHED;
            if (e.code == w.code) begin
              e.stop   = w.now;
              e.state  = ENT_CLEARED;
              store[s] = e;
              r.action = ACT_CLEARED;
            end
            ev_status[w.code] = 1'b0;
            r.slot            = s;
            r.entry           = e;
          end
        end
        default: r.action = ACT_BAD_CODE;
      endcase
      return r;
    endfunction

    function void note_request(request_t w);
      result_t r;
      r = apply_request(w);
      due_results.push_back(r);
      act_count[r.action]++;
    endfunction

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("%s got %0d expected %0d (result %0d)", name, got, want, checked));
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result word with nothing expected, action %0d", got.action));
      end else begin
        want = due_results.pop_front();
        compare_field("action", 8'(got.action), 8'(want.action));
        compare_field("slot", 8'(got.slot), 8'(want.slot));
        compare_field("entry_code", 8'(got.entry.code), 8'(want.entry.code));
        compare_field("entry_state", 8'(got.entry.state), 8'(want.entry.state));
        compare_field("start_minute", 8'(got.entry.start.minute),
                      8'(want.entry.start.minute));
        compare_field("start_hour", 8'(got.entry.start.hour),
                      8'(want.entry.start.hour));
        compare_field("start_day", 8'(got.entry.start.day),
                      8'(want.entry.start.day));
        compare_field("start_month", 8'(got.entry.start.month),
                      8'(want.entry.start.month));
        compare_field("end_minute", 8'(got.entry.stop.minute),
                      8'(want.entry.stop.minute));
        compare_field("end_hour", 8'(got.entry.stop.hour),
                      8'(want.entry.stop.hour));
        compare_field("end_day", 8'(got.entry.stop.day),
                      8'(want.entry.stop.day));
        compare_field("end_month", 8'(got.entry.stop.month),
                      8'(want.entry.stop.month));
      end
      checked++;
    endtask

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tfel_in_if  in_ch ();
  tfel_out_if out_ch ();

  timestamped_fault_event_log dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fault_log_scoreboard sb;

  int snd_idle;
  int rcv_stall;
  int hold_left;
  int words_sent;
  int idle_cycles = 0;

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Build a request word from plain values
  function automatic request_t make_word(req_type_t rq, int code, bit act,
                                         int mi, int hr, int dy, int mo, int rd);
    request_t w;
    w.req        = rq;
    w.code       = code[4:0];
    w.active     = act;
    w.now.minute = mi[5:0];
    w.now.hour   = hr[4:0];
    w.now.day    = dy[4:0];
    w.now.month  = mo[3:0];
    w.rd_slot    = rd[5:0];
    return w;
  endfunction

  // Mostly reports that flip an event's status, some reads, some unused request codes, rare log clears
  function automatic request_t random_word();
    request_t w;
    int       pick;
    int       code;
    bit       act;
    pick = $urandom_range(999);
    code = $urandom_range(NUM_EVENTS - 1);
    act  = 1'($urandom_range(1));
    w = make_word(REQ_REPORT, code, act, $urandom_range(59), $urandom_range(23),
                  $urandom_range(31, 1), $urandom_range(11), $urandom_range(63));
    if (pick < 3) begin
      w.req = REQ_CLEAR;
    end else if (pick < 25) begin
      w.req = REQ_NONE;
    end else if (pick < 175) begin
      w.req = REQ_READ;
    end else if ($urandom_range(99) < 85) begin
      w.active = !sb.ev_status[code];
    end
    return w;
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(request_t w);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < snd_idle) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.req_type     <= w.req;
    in_ch.event_num    <= w.code;
    in_ch.event_active <= w.active;
    in_ch.now_minute   <= w.now.minute;
    in_ch.now_hour     <= w.now.hour;
    in_ch.now_day      <= w.now.day;
    in_ch.now_month    <= w.now.month;
    in_ch.read_slot    <= w.rd_slot;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(w);
    words_sent++;
  endtask

  // Result side: check accepted words, then pick the next ready value
  initial begin
    result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.action            = action_t'(out_ch.action);
        got.slot              = out_ch.slot;
        got.entry.code        = out_ch.entry_code;
        got.entry.state       = entry_state_t'(out_ch.entry_state);
        got.entry.start.minute = out_ch.start_minute;
        got.entry.start.hour   = out_ch.start_hour;
        got.entry.start.day    = out_ch.start_day;
        got.entry.start.month  = out_ch.start_month;
        got.entry.stop.minute  = out_ch.end_minute;
        got.entry.stop.hour    = out_ch.end_hour;
        got.entry.stop.day     = out_ch.end_day;
        got.entry.stop.month   = out_ch.end_month;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    sb          = new();
    snd_idle    = 0;
    rcv_stall   = 0;
    hold_left   = 0;
    words_sent  = 0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= REQ_REPORT;
    in_ch.event_num    <= '0;
    in_ch.event_active <= 1'b0;
    in_ch.now_minute   <= '0;
    in_ch.now_hour     <= '0;
    in_ch.now_day      <= '0;
    in_ch.now_month    <= '0;
    in_ch.read_slot    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: edge values and every action but already open and unmatched
    send_word(make_word(REQ_CLEAR, 0, 0, 0, 0, 1, 0, 0));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 1, 0, 0));
    send_word(make_word(REQ_READ, 31, 1, 59, 23, 31, 11, 63));
    send_word(make_word(REQ_REPORT, 0, 0, 12, 3, 4, 5, 0));
    send_word(make_word(REQ_REPORT, 31, 1, 59, 23, 31, 11, 0));
    send_word(make_word(REQ_REPORT, 31, 1, 1, 1, 1, 1, 0));
    send_word(make_word(REQ_REPORT, 0, 1, 0, 0, 1, 0, 63));
    send_word(make_word(REQ_REPORT, 31, 0, 30, 12, 15, 6, 0));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 1, 0, 1));
    send_word(make_word(REQ_REPORT, 31, 1, 45, 16, 16, 8, 0));
    send_word(make_word(REQ_NONE, 31, 1, 59, 23, 31, 11, 63));
    send_word(make_word(REQ_REPORT, 0, 0, 59, 23, 31, 11, 0));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 1, 0, 60));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 1, 0, 2));
    send_word(make_word(REQ_CLEAR, 31, 1, 59, 23, 31, 11, 63));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 1, 0, 3));
    send_word(make_word(REQ_REPORT, 31, 0, 7, 7, 7, 7, 0));
    send_word(make_word(REQ_REPORT, 7, 1, 32, 16, 16, 8, 0));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 1, 0, 1));

    // Random passes: no idling, sender idle, receiver stall, both, hold-off
    for (int pass = 0; pass < 5; pass++) begin
      case (pass)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 78; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 78; end
        3: begin snd_idle = 28; rcv_stall = 28; end
        default: begin
          snd_idle  = 0;
          rcv_stall = 0;
          hold_left = HOLD_CYCLES;
        end
      endcase
      for (int k = 0; k < WORDS_PER_PASS; k++) send_word(random_word());
    end
    in_ch.valid <= 1'b0;

    // Drain and let any stray word show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d request words sent, %0d result words checked, %0d mismatches",
             words_sent, sb.checked, sb.errors);
    $display({"summary: opened %0d, already open %0d, cleared %0d, unmatched %0d, ",
              "unchanged %0d, read %0d, log clear %0d, bad %0d"},
             sb.act_count[ACT_OPENED], sb.act_count[ACT_ALREADY_OP],
             sb.act_count[ACT_CLEARED], sb.act_count[ACT_UNMATCHED],
             sb.act_count[ACT_UNCHANGED], sb.act_count[ACT_READ],
             sb.act_count[ACT_LOG_CLEAR], sb.act_count[ACT_BAD_CODE]);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tfel_pkg.sv
rtl/tfel_if.sv
rtl/tfel_ram.sv
rtl/timestamped_fault_event_log.sv
tb/testbench.sv
